// ----- hdl/tsh_pkg.sv -----
// shared types, constants and trit functions of the ternary sponge hash
`default_nettype none

package tsh_pkg;

  localparam int unsigned STATE_TRITS   = 729;
  localparam int unsigned RATE_TRITS_DEF = 243;
  localparam int unsigned WALK_STEP     = 364;
  localparam int unsigned ROUND_W       = 7;
  localparam logic [ROUND_W-1:0] ROUNDS_MAX  = ROUND_W'(81);
  localparam logic [ROUND_W-1:0] ROUNDS_RST  = ROUND_W'(81);
  localparam logic [ROUND_W-1:0] ROUNDS_MIN  = ROUND_W'(1);

  typedef logic [1:0] trit_t;

  localparam trit_t TRIT_ZERO = 2'b00;
  localparam trit_t TRIT_POS  = 2'b01;
  localparam trit_t TRIT_NEG  = 2'b11;

  typedef enum logic [1:0] {
    MODE_ABSORB  = 2'd0,
    MODE_SQUEEZE = 2'd1,
    MODE_CLEAR   = 2'd2
  } mode_e;

  typedef struct packed {
    logic write;
    logic read;
    logic clear;
    logic round;
    logic pos_next;
    logic pos_zero;
  } dp_cmd_t;

  typedef struct packed {
    logic pos_end;
  } dp_status_t;

  // bit pattern minus two saturates to minus one
  function automatic trit_t norm_trit(input trit_t t);
    trit_t r;
    if (t == TRIT_ZERO) begin
      r = TRIT_ZERO;
    end else if (t == TRIT_POS) begin
      r = TRIT_POS;
    end else begin
      r = TRIT_NEG;
    end
    return r;
  endfunction

  // 3x3 truth table on the walk pair
  function automatic trit_t mix_trit(input trit_t a, input trit_t b);
    trit_t r;
    case ({a, b})
      {TRIT_NEG,  TRIT_NEG}:  r = TRIT_POS;
      {TRIT_ZERO, TRIT_NEG}:  r = TRIT_ZERO;
      {TRIT_POS,  TRIT_NEG}:  r = TRIT_NEG;
      {TRIT_NEG,  TRIT_ZERO}: r = TRIT_POS;
      {TRIT_ZERO, TRIT_ZERO}: r = TRIT_NEG;
      {TRIT_POS,  TRIT_ZERO}: r = TRIT_ZERO;
      {TRIT_NEG,  TRIT_POS}:  r = TRIT_NEG;
      {TRIT_ZERO, TRIT_POS}:  r = TRIT_POS;
      {TRIT_POS,  TRIT_POS}:  r = TRIT_ZERO;
      default:                r = TRIT_ZERO;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/tsh_datapath.sv -----
// sponge state cells, block position, round logic and output trit register
`default_nettype none

module tsh_datapath
  import tsh_pkg::*;
#(
  parameter int unsigned RATE_TRITS = RATE_TRITS_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire dp_cmd_t cmd_i,
  output dp_status_t status_o,
  input  wire trit_t trit_in_i,
  output trit_t      trit_out_o
);

  localparam int unsigned PosW = (RATE_TRITS > 1) ? $clog2(RATE_TRITS) : 1;

  trit_t state_q [STATE_TRITS];
  trit_t state_d [STATE_TRITS];
  trit_t mixed [STATE_TRITS];
  trit_t rate_view [RATE_TRITS];
  logic [STATE_TRITS-1:0] wr_hit;
  logic [PosW-1:0] pos_q, pos_d;
  trit_t trit_out_q;
  trit_t trit_wr;

  assign trit_wr = norm_trit(trit_in_i);

  // one full round: every cell reads its fixed pair of the walk
  for (genvar g = 0; g < STATE_TRITS; g++) begin : g_cell
    localparam int unsigned WA = (g * WALK_STEP) % STATE_TRITS;
    localparam int unsigned WB = ((g + 1) * WALK_STEP) % STATE_TRITS;
    assign mixed[g] = mix_trit(state_q[WA], state_q[WB]);
    if (g < RATE_TRITS) begin : g_rate
      assign wr_hit[g] = cmd_i.write && (pos_q == PosW'(g));
      assign rate_view[g] = state_q[g];
    end else begin : g_cap
      assign wr_hit[g] = 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < STATE_TRITS; i++) begin
      if (cmd_i.clear) begin
        state_d[i] = TRIT_ZERO;
      end else if (cmd_i.round) begin
        state_d[i] = mixed[i];
      end else if (wr_hit[i]) begin
        state_d[i] = trit_wr;
      end else begin
        state_d[i] = state_q[i];
      end
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.pos_zero) begin
      pos_d = '0;
    end else if (cmd_i.pos_next) begin
      pos_d = pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{default: TRIT_ZERO};
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      trit_out_q <= rate_view[pos_q];
    end
  end

  assign status_o.pos_end = (pos_q == PosW'(RATE_TRITS - 1));
  assign trit_out_o = trit_out_q;

endmodule

`default_nettype wire

// ----- hdl/tsh_ctrl.sv -----
// item handshake, round sequencer and round count register
`default_nettype none

module tsh_ctrl
  import tsh_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire  [1:0]        mode_i,
  input  wire               last_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire [ROUND_W-1:0] round_count_i,
  output dp_cmd_t           cmd_o,
  input  wire dp_status_t   status_i
);

  typedef enum logic {
    ST_IDLE,
    ST_PERMUTE
  } state_e;

  state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic [ROUND_W-1:0] round_cnt_q, round_cnt_d;
  logic [ROUND_W-1:0] round_count_q;
  logic [ROUND_W-1:0] rounds_last;
  logic accept;
  logic block_end;
  mode_e mode;

  assign mode = mode_e'(mode_i);
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept = in_valid_i && in_ready_o;
  assign block_end = last_i || status_i.pos_end;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  // zero rounds acts as one, above the maximum saturates
  always_comb begin
    if (round_count_q == '0) begin
      rounds_last = ROUNDS_MIN - ROUND_W'(1);
    end else if (round_count_q > ROUNDS_MAX) begin
      rounds_last = ROUNDS_MAX - ROUND_W'(1);
    end else begin
      rounds_last = round_count_q - ROUND_W'(1);
    end
  end

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    round_cnt_d = round_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        round_cnt_d = '0;
        if (accept) begin
          case (mode)
            MODE_ABSORB, MODE_SQUEEZE: begin
              cmd_o.write = (mode == MODE_ABSORB);
              cmd_o.read  = (mode == MODE_SQUEEZE);
              if (mode == MODE_SQUEEZE) begin
                out_valid_d = 1'b1;
              end
              if (block_end) begin
                cmd_o.pos_zero = 1'b1;
                state_d        = ST_PERMUTE;
              end else begin
                cmd_o.pos_next = 1'b1;
              end
            end
            MODE_CLEAR: begin
              cmd_o.clear    = 1'b1;
              cmd_o.pos_zero = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ST_PERMUTE: begin
        cmd_o.round = 1'b1;
        if (round_cnt_q == rounds_last) begin
          round_cnt_d = '0;
          state_d     = ST_IDLE;
        end else begin
          round_cnt_d = round_cnt_q + ROUND_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      round_cnt_q   <= '0;
      round_count_q <= ROUNDS_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      round_cnt_q <= round_cnt_d;
      if (cfg_valid_i) begin
        round_count_q <= round_count_i;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ternary_sponge_hash.sv -----
// ternary sponge hash top level: controller, state datapath and checks
// an absorb or squeeze beat is taken while idle and the output trit is empty or being taken;
// a beat that ends a block (position wraps or last set) starts a permutation of 1 to 81 rounds
// no beat is accepted while the permutation rounds run
// squeezed trits appear in the cycle after their beat and wait in an output register
// reset clears all 729 trits, the position and the sequencer; round count goes to 81
`default_nettype none

module ternary_sponge_hash
  import tsh_pkg::*;
#(
  parameter int unsigned RATE_TRITS = RATE_TRITS_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  wire  [1:0]        mode_i,
  input  wire  [1:0]        trit_in_i,
  input  wire               last_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output logic [1:0]        trit_out_o,
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire [ROUND_W-1:0] round_count_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tsh_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .last_i        (last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .round_count_i (round_count_i),
    .cmd_o         (cmd),
    .status_i      (status)
  );

  tsh_datapath #(
    .RATE_TRITS (RATE_TRITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .trit_in_i  (trit_in_i),
    .trit_out_o (trit_out_o)
  );

  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.write, cmd.read, cmd.clear, cmd.round}))
    else $error("datapath commands overlap");

  a_no_accept_in_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.round |-> !in_ready_o)
    else $error("beat accepted during permutation");

  a_squeeze_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (mode_i == MODE_SQUEEZE)) |=> out_valid_o)
    else $error("squeeze beat gave no result");

  a_last_permutes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_i &&
     ((mode_i == MODE_ABSORB) || (mode_i == MODE_SQUEEZE))) |=> cmd.round)
    else $error("last beat did not start permutation");

endmodule

`default_nettype wire

// ----- tb/ternary_sponge_hash_checker.sv -----
// checker that models the ternary sponge and compares every squeezed trit
`timescale 1ns / 100ps

module ternary_sponge_hash_checker
  import tsh_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               in_ready_i,
  input  wire  [1:0]        mode_i,
  input  wire  [1:0]        trit_in_i,
  input  wire               last_i,
  input  wire               out_valid_i,
  input  wire               out_ready_i,
  input  wire  [1:0]        trit_out_i,
  input  wire               cfg_valid_i,
  input  wire               cfg_ready_i,
  input  wire [ROUND_W-1:0] round_count_i,
  output int                pending_o,
  output int                errors_o
);

  localparam int MIX [9] = '{1, 0, -1, 1, -1, 0, -1, 1, 0};

  trit_t              sponge [STATE_TRITS];
  int unsigned        position;
  logic [ROUND_W-1:0] rounds;
  trit_t              squeezed_trits [$];
  int                 mismatches;

  function automatic int trit_value(input trit_t t);
    return (t == TRIT_POS) ? 1 : ((t == TRIT_NEG) ? -1 : 0);
  endfunction

  task automatic permute_sponge();
    trit_t       prior [STATE_TRITS];
    int unsigned n;
    int unsigned walk;
    int unsigned here;
    n = rounds;
    if (n < ROUNDS_MIN) n = ROUNDS_MIN;
    if (n > ROUNDS_MAX) n = ROUNDS_MAX;
    for (int r = 0; r < n; r++) begin
      prior = sponge;
      walk = 0;
      for (int i = 0; i < STATE_TRITS; i++) begin
        here = walk;
        walk = (walk <= WALK_STEP) ? walk + WALK_STEP : walk - WALK_STEP - 1;
        sponge[i] = trit_t'(MIX[trit_value(prior[here]) + 3 * trit_value(prior[walk]) + 4]);
      end
    end
  endtask

  task automatic advance_position(input logic ends_block);
    position++;
    if (position >= RATE_TRITS_DEF || ends_block) begin
      permute_sponge();
      position = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (sponge[i]) sponge[i] = TRIT_ZERO;
      position = 0;
      rounds = ROUNDS_RST;
      squeezed_trits.delete();
      mismatches = 0;
      pending_o <= 0;
      errors_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (squeezed_trits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result beat with nothing expected: got %0d", $signed(trit_out_i));
          end
        end else if (squeezed_trits[0] !== trit_out_i) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("trit_out mismatch: expected %0d got %0d",
                     $signed(squeezed_trits[0]), $signed(trit_out_i));
          end
          void'(squeezed_trits.pop_front());
        end else begin
          void'(squeezed_trits.pop_front());
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        rounds = round_count_i;
      end
      if (in_valid_i && in_ready_i) begin
        case (mode_i)
          MODE_ABSORB: begin
            sponge[position] = (trit_in_i == TRIT_ZERO) ? TRIT_ZERO :
                               ((trit_in_i == TRIT_POS) ? TRIT_POS : TRIT_NEG);
            advance_position(last_i);
          end
          MODE_SQUEEZE: begin
            squeezed_trits.push_back(sponge[position]);
            advance_position(last_i);
          end
          MODE_CLEAR: begin
            foreach (sponge[i]) sponge[i] = TRIT_ZERO;
            position = 0;
          end
          default: begin
          end
        endcase
      end
      pending_o <= squeezed_trits.size();
      errors_o <= mismatches;
    end
  end

endmodule

// ----- tb/ternary_sponge_hash_test.sv -----
// testbench top for the ternary sponge hash: stimulus, idling and verdict
`timescale 1ns / 100ps

module ternary_sponge_hash_test;
  import tsh_pkg::*;

  localparam logic [1:0]  MODE_UNUSED    = 2'd3;
  localparam logic [1:0]  TRIT_MINUS_TWO = 2'b10;
  localparam int unsigned CYCLE_LIMIT    = 1000000;
  localparam int unsigned SETTLE_CYCLES  = 100;

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic [1:0]         mode        = MODE_ABSORB;
  logic [1:0]         trit_in     = TRIT_ZERO;
  logic               last        = 1'b0;
  logic               out_ready   = 1'b0;
  logic               cfg_valid   = 1'b0;
  logic [ROUND_W-1:0] round_count = ROUNDS_RST;
  logic               steady      = 1'b0;
  wire                in_ready;
  wire                out_valid;
  wire                cfg_ready;
  wire  [1:0]         trit_out;
  int                 pending;
  int                 errors;
  int unsigned        cycle_count;

  logic [ROUND_W-1:0] phase_rounds [7] = '{7'd81, 7'd1, 7'd0, 7'd127, 7'd27, 7'd2, 7'd81};

  ternary_sponge_hash dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .mode_i        (mode),
    .trit_in_i     (trit_in),
    .last_i        (last),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .trit_out_o    (trit_out),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .round_count_i (round_count)
  );

  ternary_sponge_hash_checker checker_inst (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .mode_i        (mode),
    .trit_in_i     (trit_in),
    .last_i        (last),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .trit_out_i    (trit_out),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .round_count_i (round_count),
    .pending_o     (pending),
    .errors_o      (errors)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 30);
  end

  function automatic logic [1:0] any_trit();
    return 2'($urandom_range(3));
  endfunction

  task automatic send_beat(input logic [1:0] m, input logic [1:0] t, input logic l);
    if (!steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    trit_in <= t;
    last <= l;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rounds(input logic [ROUND_W-1:0] value);
    cfg_valid <= 1'b1;
    round_count <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_messages(input int unsigned items);
    int unsigned sent;
    int unsigned len;
    logic        closes;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        send_beat(2'($urandom_range(3)), any_trit(), 1'($urandom_range(1)));
        sent++;
      end else begin
        len = $urandom_range(1, 24);
        closes = ($urandom_range(4) != 0);
        for (int k = 0; k < len; k++) begin
          send_beat(MODE_ABSORB, any_trit(), closes && (k == len - 1));
        end
        sent += len;
        len = $urandom_range(1, 12);
        closes = ($urandom_range(1) == 1);
        for (int k = 0; k < len; k++) begin
          send_beat(MODE_SQUEEZE, any_trit(), closes && (k == len - 1));
        end
        sent += len;
      end
    end
  endtask

  // long run without last so the position wraps at the block end
  task automatic run_long();
    for (int k = 0; k < 250; k++) begin
      steady = (k < 120);
      send_beat(($urandom_range(1) == 1) ? MODE_SQUEEZE : MODE_ABSORB, any_trit(), 1'b0);
    end
    steady = 1'b0;
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ternary_sponge_hash_test NOT OK");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_beat(MODE_SQUEEZE, TRIT_ZERO, 1'b0);
    send_beat(MODE_ABSORB, TRIT_POS, 1'b0);
    send_beat(MODE_ABSORB, TRIT_NEG, 1'b0);
    send_beat(MODE_ABSORB, TRIT_MINUS_TWO, 1'b0);
    send_beat(MODE_ABSORB, TRIT_ZERO, 1'b1);
    repeat (3) send_beat(MODE_SQUEEZE, TRIT_POS, 1'b0);
    send_beat(MODE_SQUEEZE, TRIT_NEG, 1'b1);
    send_beat(MODE_UNUSED, TRIT_POS, 1'b1);
    send_beat(MODE_SQUEEZE, TRIT_ZERO, 1'b0);
    send_beat(MODE_CLEAR, TRIT_NEG, 1'b1);
    send_beat(MODE_SQUEEZE, TRIT_ZERO, 1'b1);
    send_beat(MODE_ABSORB, TRIT_MINUS_TWO, 1'b1);
    repeat (2) send_beat(MODE_SQUEEZE, TRIT_ZERO, 1'b0);
    send_beat(MODE_CLEAR, TRIT_ZERO, 1'b0);
    send_beat(MODE_UNUSED, TRIT_ZERO, 1'b0);
    send_beat(MODE_SQUEEZE, TRIT_ZERO, 1'b0);

    foreach (phase_rounds[p]) begin
      settle();
      write_rounds(phase_rounds[p]);
      if (phase_rounds[p] == ROUNDS_MIN) begin
        run_long();
      end else begin
        run_messages(20);
      end
    end
    settle();

    if (errors == 0) begin
      $display("ternary_sponge_hash_test OK");
    end else begin
      $display("ternary_sponge_hash_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/tsh_pkg.sv
hdl/tsh_datapath.sv
hdl/tsh_ctrl.sv
hdl/ternary_sponge_hash.sv
tb/ternary_sponge_hash_checker.sv
tb/ternary_sponge_hash_test.sv
